@@ rtl/bcp_pkg.sv @@
// shared constants, codes and types for the bounded candidate pool
package bcp_pkg;

    localparam int POOL_ENTRIES_DEF = 256;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 32;
    localparam int IDX_IN_W   = 8;
    localparam int OUTCOME_W  = 3;
    localparam int SLOT_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int S_DATA_W   = POS_W + IDX_IN_W;
    localparam int M_FIELDS_W = SLOT_W + POS_W + 1 + COUNT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_DUPLICATE = 3'd0,
        OC_APPENDED  = 3'd1,
        OC_REPLACED  = 3'd2,
        OC_DROPPED   = 3'd3,
        OC_CLEARED   = 3'd4,
        OC_READ      = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DECIDE
    } state_t;

endpackage

@@ rtl/bcp_store.sv @@
// entry storage: one write port, one registered read port
module bcp_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bounded_candidate_pool.sv @@
// bounded candidate pool: top level with scan sequencer and result register
// add: one memory read per stored entry, two compare stages, leaving the scan and a decide step
// that writes back; read takes a read step and the decide step, clear the decide step alone,
// plus any wait for the result register
// one transaction is worked on at a time; the next is taken the cycle after the result loads
// reset clears count, anchor and handshake state at once; entry contents stay unknown
module bounded_candidate_pool
    import bcp_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // start_position [31:0], entry_index [39:32]
    input  logic [S_DATA_W-1:0]  s_tdata,
    // command [1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot_written [7:0], entry_value [39:8], entry_valid [40], entry_count [49:41], zeros
    output logic [M_DATA_W-1:0]  m_tdata,
    // outcome [2:0]
    output logic [OUTCOME_W-1:0] m_tuser
);

    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(POOL_ENTRIES);

    function automatic logic [POS_W-1:0] abs_gap(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W-1:0] r;
        if (a > b)
        begin
            r = a - b;
        end
        else
        begin
            r = b - a;
        end
        return r;
    endfunction

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  anchor_reg, anchor_next;
    logic              anchor_present_reg, anchor_present_next;
    logic              m_tvalid_reg;
    logic              v1_reg, v2_reg;

    // captured transaction and scan payload
    logic [CMD_W-1:0]    cmd_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [IDX_IN_W-1:0] idx_reg;
    logic [CNT_W-1:0]    issue_ptr_reg;
    logic [IDX_W-1:0]    idx1_reg, idx2_reg, worst_idx_reg;
    logic [POS_W-1:0]    gap_reg, worst_gap_reg, new_gap_reg;
    logic                dup_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    outcome_t            m_tuser_reg;

    logic             accept;
    logic             out_free;
    logic             scan_issue;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [POS_W-1:0] rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             out_load;
    outcome_t         res_outcome;
    logic [IDX_W-1:0] res_slot;
    logic [POS_W-1:0] res_value;
    logic             res_valid;

    logic [IDX_W+IDX_IN_W-1:0] idx_wide;
    logic [CNT_W+IDX_IN_W-1:0] idx_cmp;
    logic [CNT_W+IDX_IN_W-1:0] cnt_cmp;
    logic [IDX_W+SLOT_W-1:0]   slot_wide;
    logic [CNT_W+COUNT_W-1:0]  cnt_wide;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign scan_issue = (state_reg == ST_SCAN) && (issue_ptr_reg < count_reg);

    assign idx_wide = {{IDX_W{1'b0}}, idx_reg};
    assign idx_cmp  = {{CNT_W{1'b0}}, idx_reg};
    assign cnt_cmp  = {{IDX_IN_W{1'b0}}, count_reg};

    assign rd_en   = scan_issue || (state_reg == ST_READ);
    assign rd_addr = (state_reg == ST_READ) ? idx_wide[IDX_W-1:0]
                                            : issue_ptr_reg[IDX_W-1:0];

    bcp_store #(
        .DEPTH  (POOL_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (POS_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pos_reg)
    );

    // next state, write-back and result
    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        anchor_next         = anchor_reg;
        anchor_present_next = anchor_present_reg;
        wr_en               = 1'b0;
        wr_addr             = count_reg[IDX_W-1:0];
        out_load            = 1'b0;
        res_outcome         = OC_READ;
        res_slot            = '0;
        res_value           = '0;
        res_valid           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[1])
                    begin
                        state_next = ST_READ;
                    end
                    else if (s_tuser == CMD_CLEAR)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // scan is over once every read has passed the compare stages
                if (!scan_issue && !v1_reg && !v2_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (cmd_reg[1])
                    begin
                        res_outcome = OC_READ;
                        res_valid   = (idx_cmp < cnt_cmp);
                        res_value   = res_valid ? rd_data : '0;
                    end
                    else if (cmd_reg == CMD_CLEAR)
                    begin
                        res_outcome         = OC_CLEARED;
                        count_next          = '0;
                        anchor_next         = '0;
                        anchor_present_next = 1'b0;
                    end
                    else if (dup_reg)
                    begin
                        res_outcome = OC_DUPLICATE;
                    end
                    else
                    begin
                        if (!anchor_present_reg)
                        begin
                            anchor_next         = pos_reg;
                            anchor_present_next = 1'b1;
                        end
                        if (count_reg < FULL_COUNT)
                        begin
                            res_outcome = OC_APPENDED;
                            res_slot    = count_reg[IDX_W-1:0];
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[IDX_W-1:0];
                            count_next  = count_reg + 1'b1;
                        end
                        else if (new_gap_reg < worst_gap_reg)
                        begin
                            res_outcome = OC_REPLACED;
                            res_slot    = worst_idx_reg;
                            wr_en       = 1'b1;
                            wr_addr     = worst_idx_reg;
                        end
                        else
                        begin
                            res_outcome = OC_DROPPED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign slot_wide = {{SLOT_W{1'b0}}, res_slot};
    assign cnt_wide  = {{COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            count_reg          <= '0;
            anchor_reg         <= '0;
            anchor_present_reg <= 1'b0;
            m_tvalid_reg       <= 1'b0;
            v1_reg             <= 1'b0;
            v2_reg             <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            count_reg          <= count_next;
            anchor_reg         <= anchor_next;
            anchor_present_reg <= anchor_present_next;
            v1_reg             <= scan_issue;
            v2_reg             <= v1_reg;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // capture, scan pipeline and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= s_tuser;
            pos_reg       <= s_tdata[POS_W-1:0];
            idx_reg       <= s_tdata[S_DATA_W-1:POS_W];
            issue_ptr_reg <= '0;
            dup_reg       <= 1'b0;
            worst_gap_reg <= '0;
            worst_idx_reg <= '0;
        end
        else
        begin
            if (scan_issue)
            begin
                issue_ptr_reg <= issue_ptr_reg + 1'b1;
            end
            if (v1_reg && (rd_data == pos_reg))
            begin
                dup_reg <= 1'b1;
            end
            // strict compare keeps the lowest index on ties
            if (v2_reg && (gap_reg > worst_gap_reg))
            begin
                worst_gap_reg <= gap_reg;
                worst_idx_reg <= idx2_reg;
            end
        end
        idx1_reg    <= issue_ptr_reg[IDX_W-1:0];
        gap_reg     <= abs_gap(rd_data, anchor_reg);
        idx2_reg    <= idx1_reg;
        new_gap_reg <= abs_gap(pos_reg, anchor_reg);
        if (out_load)
        begin
            m_tuser_reg <= res_outcome;
            m_tdata_reg <= {{(M_DATA_W - M_FIELDS_W){1'b0}}, cnt_wide[COUNT_W-1:0],
                            res_valid, res_value, slot_wide[SLOT_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("pool count beyond depth");

    a_anchor_held: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> anchor_present_reg)
        else $error("entries stored without an anchor");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second transaction taken while busy");

    a_write_on_decide: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (out_load && (state_reg == ST_DECIDE)))
        else $error("entry written outside the decide step");

endmodule

@@ bench/pool_checker.sv @@
// result checker for the bounded candidate pool: mirrors the pool and compares every result
module pool_checker
    import bcp_pkg::*;
#(
    parameter int DEPTH = POOL_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // start_position [31:0], entry_index [39:32]
    input  logic [S_DATA_W-1:0]  s_tdata,
    // command [1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // slot_written [7:0], entry_value [39:8], entry_valid [40], entry_count [49:41], zeros
    input  logic [M_DATA_W-1:0]  m_tdata,
    // outcome [2:0]
    input  logic [OUTCOME_W-1:0] m_tuser,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen,
    output int                   replaced_seen,
    output int                   dropped_seen
);

    localparam int VALUE_LO  = SLOT_W;
    localparam int VALID_BIT = SLOT_W + POS_W;
    localparam int COUNT_LO  = VALID_BIT + 1;

    typedef struct packed {
        outcome_t             outcome;
        logic [SLOT_W-1:0]    slot;
        logic [POS_W-1:0]     value;
        logic                 valid;
        logic [COUNT_W-1:0]   count;
    } pool_result_t;

    pool_result_t     awaited_q[$];
    logic [POS_W-1:0] entries [DEPTH];
    int               stored;
    logic [POS_W-1:0] anchor;
    logic             anchor_held;

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        results_seen  = 0;
        replaced_seen = 0;
        dropped_seen  = 0;
        stored        = 0;
        anchor        = '0;
        anchor_held   = 1'b0;
    end

    function automatic logic [POS_W-1:0] pos_gap(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // applies one command to the mirrored pool and returns the result it should give
    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic [IDX_IN_W-1:0] idx, output pool_result_t r);
        int               i;
        int               far_slot;
        logic [POS_W-1:0] far_gap;
        logic             dup;

        r   = '0;
        dup = 1'b0;
        if (cmd == CMD_ADD)
        begin
            for (i = 0; i < stored; i++)
                if (entries[i] == pos)
                    dup = 1'b1;
            if (dup)
                r.outcome = OC_DUPLICATE;
            else
            begin
                if (!anchor_held)
                begin
                    anchor      = pos;
                    anchor_held = 1'b1;
                end
                if (stored < DEPTH)
                begin
                    entries[stored] = pos;
                    r.slot          = SLOT_W'(stored);
                    r.outcome       = OC_APPENDED;
                    stored++;
                end
                else
                begin
                    // farthest from the anchor, lowest slot on a tie
                    far_slot = 0;
                    far_gap  = pos_gap(entries[0], anchor);
                    for (i = 1; i < DEPTH; i++)
                        if (pos_gap(entries[i], anchor) > far_gap)
                        begin
                            far_gap  = pos_gap(entries[i], anchor);
                            far_slot = i;
                        end
                    if (pos_gap(pos, anchor) < far_gap)
                    begin
                        entries[far_slot] = pos;
                        r.slot            = SLOT_W'(far_slot);
                        r.outcome         = OC_REPLACED;
                    end
                    else
                        r.outcome = OC_DROPPED;
                end
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            stored      = 0;
            anchor      = '0;
            anchor_held = 1'b0;
            r.outcome   = OC_CLEARED;
        end
        else
        begin
            // bit 1 set means read, whatever bit 0 holds
            if (int'(idx) < stored)
            begin
                r.value = entries[idx];
                r.valid = 1'b1;
            end
            r.outcome = OC_READ;
        end
        r.count = COUNT_W'(stored);
    endtask

    task automatic report_mismatch(input string what, input logic [POS_W-1:0] got,
                                   input logic [POS_W-1:0] want);
        if (fail_count < 40)
            $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                     what, results_seen, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pool_result_t want;
        pool_result_t fresh;

        if (!rst_n)
        begin
            stored      = 0;
            anchor      = '0;
            anchor_held = 1'b0;
            awaited_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_q.size() == 0)
                    report_mismatch("result with nothing awaited", POS_W'(m_tuser), '0);
                else
                begin
                    want = awaited_q.pop_front();
                    if (m_tuser !== want.outcome)
                        report_mismatch("outcome", POS_W'(m_tuser), POS_W'(want.outcome));
                    if (m_tdata[SLOT_W-1:0] !== want.slot)
                        report_mismatch("slot_written", POS_W'(m_tdata[SLOT_W-1:0]),
                                        POS_W'(want.slot));
                    if (m_tdata[VALUE_LO +: POS_W] !== want.value)
                        report_mismatch("entry_value", m_tdata[VALUE_LO +: POS_W], want.value);
                    if (m_tdata[VALID_BIT] !== want.valid)
                        report_mismatch("entry_valid", POS_W'(m_tdata[VALID_BIT]),
                                        POS_W'(want.valid));
                    if (m_tdata[COUNT_LO +: COUNT_W] !== want.count)
                        report_mismatch("entry_count", POS_W'(m_tdata[COUNT_LO +: COUNT_W]),
                                        POS_W'(want.count));
                    if (want.outcome == OC_REPLACED)
                        replaced_seen++;
                    if (want.outcome == OC_DROPPED)
                        dropped_seen++;
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                apply_command(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W +: IDX_IN_W], fresh);
                awaited_q.insert(awaited_q.size(), fresh);
            end
        end
        pending = awaited_q.size();
    end

endmodule

@@ bench/testbench.sv @@
// top of the bounded candidate pool bench: clock, reset, stimulus, back-pressure and verdict
module testbench;
    import bcp_pkg::*;

    localparam int DEPTH        = POOL_ENTRIES_DEF;
    localparam int ITEM_TARGET  = 900;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = DEPTH + 16;

    localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_ALT = 2'd3;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = CMD_ADD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [OUTCOME_W-1:0] m_tuser;

    int fail_count;
    int pending;
    int results_seen;
    int replaced_seen;
    int dropped_seen;

    int items_sent    = 0;
    int pool_fills    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycles        = 0;

    bounded_candidate_pool #(
        .POOL_ENTRIES (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pool_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .replaced_seen (replaced_seen),
        .dropped_seen  (dropped_seen)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [IDX_IN_W-1:0] idx);
        // idling phases rotate every 64 transactions
        case ((items_sent / 64) % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 58; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
        endcase
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {idx, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic add_pos(input logic [POS_W-1:0] pos);
        send_item(CMD_ADD, pos, IDX_IN_W'($urandom));
    endtask

    task automatic clear_pool();
        send_item(CMD_CLEAR, $urandom, IDX_IN_W'($urandom));
    endtask

    task automatic read_entry(input int idx);
        send_item(($urandom_range(3) == 0) ? CMD_READ_ALT : CMD_READ, $urandom,
                  IDX_IN_W'(idx));
    endtask

    task automatic send_noise();
        send_item(CMD_W'($urandom_range(3)), $urandom, IDX_IN_W'($urandom));
    endtask

    // grid point j around the centre; the mapping is one to one so a fill gives distinct values
    function automatic logic [POS_W-1:0] grid_value(input logic [POS_W-1:0] centre,
                                                    input int j, input int step);
        return centre + POS_W'(((j < DEPTH / 2) ? j : j - DEPTH) * step);
    endfunction

    initial
    begin
        logic [POS_W-1:0] centre;
        int               step;
        int               off;
        int               n;
        int               r;
        int               k;
        int               episode;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty reads, extremes, duplicates, read past count, odd read code, clears
        send_item(CMD_READ, 32'hFFFF_FFFF, 8'd0);
        send_item(CMD_READ_ALT, 32'h0000_0000, 8'hFF);
        send_item(CMD_ADD, 32'h0000_0000, 8'hFF);
        send_item(CMD_ADD, 32'h0000_0000, 8'h00);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 8'h00);
        send_item(CMD_ADD, 32'h8000_0000, 8'h55);
        send_item(CMD_ADD, 32'h0000_0001, 8'hAA);
        send_item(CMD_ADD, 32'h7FFF_FFFF, 8'h00);
        send_item(CMD_READ, 32'h0000_0000, 8'd0);
        send_item(CMD_READ_ALT, 32'hFFFF_FFFF, 8'd1);
        send_item(CMD_READ, 32'h0000_0000, 8'd4);
        send_item(CMD_READ, 32'h0000_0000, 8'd5);
        send_item(CMD_READ, 32'hFFFF_FFFF, 8'd255);
        send_item(CMD_CLEAR, 32'hFFFF_FFFF, 8'hFF);
        send_item(CMD_READ, 32'h0000_0000, 8'd0);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 8'h00);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 8'h00);
        send_item(CMD_ADD, 32'h0000_0000, 8'h00);
        send_item(CMD_READ_ALT, 32'h0000_0000, 8'd1);
        send_item(CMD_CLEAR, 32'h0000_0000, 8'h00);

        episode = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(3))
                0:       centre = 32'h0000_0000;
                1:       centre = 32'hFFFF_FFFF;
                default: centre = $urandom;
            endcase
            if (episode % 4 == 1 && ITEM_TARGET - items_sent > 300)
            begin
                // fill to the brim with a symmetric grid, so ties on the farthest entry occur
                step = ($urandom_range(3) == 0) ? 1 : int'($urandom_range(1, 1 << 20));
                clear_pool();
                for (k = 0; k < DEPTH; k++)
                begin
                    add_pos(grid_value(centre, (k * 37) % DEPTH, step));
                    r = $urandom_range(15);
                    if (r == 0)
                        read_entry($urandom_range(DEPTH - 1));
                    else if (r == 1)
                        add_pos(centre);
                end
                pool_fills++;
                n = $urandom_range(80, 140);
                repeat (n)
                begin
                    r = $urandom_range(99);
                    if (r < 40)
                    begin
                        off = int'($urandom_range(0, 256 * step)) - 128 * step;
                        add_pos(centre + POS_W'(off));
                    end
                    else if (r < 55)
                        add_pos(grid_value(centre, $urandom_range(DEPTH - 1), step));
                    else if (r < 63)
                        add_pos($urandom);
                    else if (r < 95)
                        read_entry($urandom_range(DEPTH - 1));
                    else
                        send_noise();
                end
            end
            else
            begin
                // short run around a base value: lots of duplicates and reads near the count
                if ($urandom_range(7) != 0)
                    clear_pool();
                n = $urandom_range(1, 40);
                repeat (n)
                begin
                    r = $urandom_range(99);
                    if (r < 50)
                        add_pos(centre + POS_W'($urandom_range(15)));
                    else if (r < 68)
                        add_pos($urandom);
                    else if (r < 84)
                        read_entry($urandom_range(31));
                    else if (r < 94)
                        read_entry($urandom_range(DEPTH - 1));
                    else
                        send_noise();
                end
            end
            episode++;
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions sent, %0d results checked, %0d full-pool fills",
                 items_sent, results_seen, pool_fills);
        $display("with the pool full: %0d replacements and %0d drops", replaced_seen,
                 dropped_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bcp_pkg.sv
rtl/bcp_store.sv
rtl/bounded_candidate_pool.sv
bench/pool_checker.sv
bench/testbench.sv
